@@ sv/periodic_sync_clock_offset_tracker_macros.svh @@
// Assertion macros used by the offset tracker checker.
`ifndef PERIODIC_SYNC_CLOCK_OFFSET_TRACKER_MACROS_SVH
`define PERIODIC_SYNC_CLOCK_OFFSET_TRACKER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PSCOT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PSCOT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/pscot_pkg.sv @@
// Shared widths, command codes and constants of the clock offset tracker.
package pscot_pkg;

   // Stream word widths
   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 1;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int RATE_W     = 20;
   localparam logic [0:0] REG_TICK_RATE = 1'b0;
   localparam logic [RATE_W-1:0] RATE_RESET = 20'd32768;

   // Command codes
   localparam logic [2:0] CMD_REPORT   = 3'd0;
   localparam logic [2:0] CMD_SET_WALL = 3'd1;
   localparam logic [2:0] CMD_CORRECT  = 3'd2;
   localparam logic [2:0] CMD_SYNC     = 3'd3;
   localparam logic [2:0] CMD_READ     = 3'd4;

   // Serial arithmetic: divisors and step counts
   localparam logic [19:0] MS_DIV  = 20'd1000;
   localparam logic [19:0] PPM_DIV = 20'd1000000;
   localparam int          ACC_W   = 53;  // 33-bit ms times 20-bit rate
   localparam logic [5:0]  MUL_STEPS      = 6'd20;
   localparam logic [5:0]  MS_DIV_STEPS   = 6'd53;
   localparam logic [5:0]  TRIM_DIV_STEPS = 6'd38;
   localparam logic [5:0]  LIM_DIV_STEPS  = 6'd37;

endpackage

@@ sv/periodic_sync_clock_offset_tracker.sv @@
// Clock offset tracker: turns a free-running tick count into a synchronized timestamp.
//
// Each request word carries a command, the tick count at the event, a value and an ok
// flag; each one yields exactly one response word with tick + offset, the measured
// interval error of a subevent report and a reject flag. Set wall clock, correction,
// read and failed events finish at once and stream at one per clock while responses
// are not stalled. A good subevent report runs through difference, magnitude, error,
// limit check and offset update. A good sync transfer scales the interval in 1.25 ms
// units to ticks by a bit-serial multiplier (one rate bit per cycle), and three
// one-bit-per-cycle restoring divisions by 1000 and 1000000 form the trimmed interval
// and the error limit. One request is worked on at a time; a finished response waits
// in a staging register and an output register, so the next request is taken while
// a response is still pending. The tick rate register (byte address 0) is written over
// the APB port; the user must write it only while idle; the block does not enforce it.
module periodic_sync_clock_offset_tracker (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [pscot_pkg::REQ_DATA_W-1:0]     req_tdata,  // event tick, value
   input  logic [pscot_pkg::REQ_USER_W-1:0]     req_tuser,  // cmd[2:0], event_ok
   // response stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [pscot_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // timestamp, measured_error
   output logic [pscot_pkg::RSP_USER_W-1:0]     rsp_tuser,  // error_rejected
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pscot_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pscot_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pscot_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);
   import pscot_pkg::*;

   // Sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_RPT_ABS  = 4'd1;
   localparam logic [3:0] S_RPT_ERR  = 4'd2;
   localparam logic [3:0] S_RPT_UPD  = 4'd3;
   localparam logic [3:0] S_MUL      = 4'd4;
   localparam logic [3:0] S_DIV_MS   = 4'd5;
   localparam logic [3:0] S_TRIM_LD  = 4'd6;
   localparam logic [3:0] S_DIV_TRIM = 4'd7;
   localparam logic [3:0] S_LIM_LD   = 4'd8;
   localparam logic [3:0] S_DIV_LIM  = 4'd9;

   // Request fields
   logic [2:0]  req_cmd;
   logic        req_ok;
   logic [31:0] req_tick;
   logic [31:0] req_value;

   assign req_cmd   = req_tuser[2:0];
   assign req_ok    = req_tuser[3];
   assign req_tick  = req_tdata[31:0];
   assign req_value = req_tdata[63:32];

   // Architectural state
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] last_rpt_ff, last_rpt_in;
   logic [31:0] last_good_ff, last_good_in;
   logic [31:0] exp_ff, exp_in;
   logic [31:0] limit_ff, limit_in;

   // Sequencer and serial datapath
   logic [3:0]        state_ff, state_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [ACC_W-1:0]  dvd_ff, dvd_in;
   logic [19:0]       rem_ff, rem_in;
   logic [32:0]       ms_ff, ms_in;
   logic [RATE_W-1:0] mlt_ff, mlt_in;
   logic              dsel_ff, dsel_in;
   logic [31:0]       work_ff, work_in;

   // Staging and output registers
   logic        stg_valid_ff, stg_valid_in;
   logic [31:0] stg_tick_ff, stg_tick_in;
   logic [31:0] stg_err_ff, stg_err_in;
   logic        stg_rej_ff, stg_rej_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_ts_ff, rsp_ts_in;
   logic [31:0] rsp_err_ff, rsp_err_in;
   logic        rsp_rej_ff, rsp_rej_in;

   // Handshakes
   logic out_free, stg_move, req_accept, csr_write;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign stg_move   = stg_valid_ff && out_free;
   assign req_tready = (state_ff == S_IDLE) && (!stg_valid_ff || out_free);
   assign req_accept = req_tvalid && req_tready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_err_ff, rsp_ts_ff};
   assign rsp_tuser  = rsp_rej_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_TICK_RATE) ?
                       {{(CSR_DATA_W-RATE_W){1'b0}}, rate_ff} : '0;

   // Interval in 1.25 ms units to whole ms: floor(10 * value / 8)
   logic [35:0] ms10;
   assign ms10 = ({4'b0, req_value} << 3) + ({4'b0, req_value} << 1);

   // Constant scalings of the work register: 36 * t and 20 * t
   logic [37:0] t36;
   logic [36:0] t20;
   assign t36 = ({6'b0, work_ff} << 5) + ({6'b0, work_ff} << 2);
   assign t20 = ({5'b0, work_ff} << 4) + ({5'b0, work_ff} << 2);

   // Shift-add multiplier step, one rate bit per cycle
   logic [33:0] mul_sum;
   assign mul_sum = {1'b0, dvd_ff[ACC_W-1:RATE_W]} + (mlt_ff[0] ? {1'b0, ms_ff} : 34'd0);

   // Restoring divider step, one quotient bit per cycle into the low end of dvd
   logic [19:0] divisor;
   logic [20:0] trial, trial_sub;
   logic        q_bit;
   logic [31:0] q_low;
   assign divisor   = dsel_ff ? PPM_DIV : MS_DIV;
   assign trial     = {rem_ff, dvd_ff[ACC_W-1]};
   assign trial_sub = trial - {1'b0, divisor};
   assign q_bit     = (trial >= {1'b0, divisor});
   assign q_low     = {dvd_ff[30:0], q_bit};

   // Report limit check, signed with one guard bit
   logic signed [32:0] err_s, lim_s, nlim_s;
   logic               reject;
   assign err_s  = $signed({work_ff[31], work_ff});
   assign lim_s  = $signed({limit_ff[31], limit_ff});
   assign nlim_s = -lim_s;
   assign reject = (err_s > lim_s) || (err_s < nlim_s);

   // Next-state logic
   always_comb begin
      rate_in      = rate_ff;
      offset_in    = offset_ff;
      last_rpt_in  = last_rpt_ff;
      last_good_in = last_good_ff;
      exp_in       = exp_ff;
      limit_in     = limit_ff;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      ms_in        = ms_ff;
      mlt_in       = mlt_ff;
      dsel_in      = dsel_ff;
      work_in      = work_ff;
      stg_valid_in = stg_valid_ff && !stg_move;
      stg_tick_in  = stg_tick_ff;
      stg_err_in   = stg_err_ff;
      stg_rej_in   = stg_rej_ff;

      if (csr_write && (csr_paddr[2] == REG_TICK_RATE)) begin
         rate_in = csr_pwdata[RATE_W-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               // commands that finish on acceptance land in the staging register at once
               stg_valid_in = 1'b1;
               stg_tick_in  = req_tick;
               stg_err_in   = '0;
               stg_rej_in   = 1'b0;
               case (req_cmd)
                  CMD_REPORT: begin
                     if (req_ok) begin
                        stg_valid_in = stg_valid_ff && !stg_move;
                        work_in      = req_tick - last_rpt_ff;
                        last_rpt_in  = req_tick;
                        state_in     = S_RPT_ABS;
                     end
                  end
                  CMD_SET_WALL: offset_in = req_value - req_tick;
                  CMD_CORRECT:  offset_in = offset_ff + req_value;
                  CMD_SYNC: begin
                     if (req_ok) begin
                        stg_valid_in = stg_valid_ff && !stg_move;
                        last_rpt_in  = req_tick;
                        ms_in        = ms10[35:3];
                        mlt_in       = rate_ff;
                        dvd_in       = '0;
                        cnt_in       = MUL_STEPS;
                        state_in     = S_MUL;
                     end
                  end
                  default: ;  // read and unused codes change nothing
               endcase
            end
         end
         S_RPT_ABS: begin
            work_in  = work_ff[31] ? (32'd0 - work_ff) : work_ff;
            state_in = S_RPT_ERR;
         end
         S_RPT_ERR: begin
            work_in  = work_ff - exp_ff;
            state_in = S_RPT_UPD;
         end
         S_RPT_UPD: begin
            if (reject) begin
               offset_in = offset_ff - last_good_ff;
            end else begin
               offset_in    = offset_ff - work_ff;
               last_good_in = work_ff;
            end
            // last_rpt_ff already holds this word's tick
            stg_valid_in = 1'b1;
            stg_tick_in  = last_rpt_ff;
            stg_err_in   = work_ff;
            stg_rej_in   = reject;
            state_in     = S_IDLE;
         end
         S_MUL: begin
            dvd_in = {mul_sum, dvd_ff[RATE_W-1:1]};
            mlt_in = mlt_ff >> 1;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               rem_in   = '0;
               dsel_in  = 1'b0;
               cnt_in   = MS_DIV_STEPS;
               state_in = S_DIV_MS;
            end
         end
         S_DIV_MS, S_DIV_TRIM, S_DIV_LIM: begin
            dvd_in = {dvd_ff[ACC_W-2:0], q_bit};
            rem_in = q_bit ? trial_sub[19:0] : trial[19:0];
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               case (state_ff)
                  S_DIV_MS: begin
                     // ticks saturate at all ones
                     work_in  = (|dvd_ff[ACC_W-2:31]) ? 32'hFFFF_FFFF : q_low;
                     state_in = S_TRIM_LD;
                  end
                  S_DIV_TRIM: begin
                     work_in  = work_ff - q_low;
                     state_in = S_LIM_LD;
                  end
                  default: begin
                     exp_in       = work_ff;
                     limit_in     = q_low;
                     stg_valid_in = 1'b1;
                     stg_tick_in  = last_rpt_ff;
                     stg_err_in   = '0;
                     stg_rej_in   = 1'b0;
                     state_in     = S_IDLE;
                  end
               endcase
            end
         end
         S_TRIM_LD: begin
            dvd_in   = {t36, 15'b0};
            rem_in   = '0;
            dsel_in  = 1'b1;
            cnt_in   = TRIM_DIV_STEPS;
            state_in = S_DIV_TRIM;
         end
         S_LIM_LD: begin
            dvd_in   = {t20, 16'b0};
            rem_in   = '0;
            dsel_in  = 1'b1;
            cnt_in   = LIM_DIV_STEPS;
            state_in = S_DIV_LIM;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output register: timestamp formed with the offset as it stands after the word
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ts_in    = rsp_ts_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_rej_in   = rsp_rej_ff;
      if (stg_move) begin
         rsp_valid_in = 1'b1;
         rsp_ts_in    = stg_tick_ff + offset_ff;
         rsp_err_in   = stg_err_ff;
         rsp_rej_in   = stg_rej_ff;
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rate_ff      <= RATE_RESET;
         offset_ff    <= '0;
         last_rpt_ff  <= '0;
         last_good_ff <= '0;
         exp_ff       <= '0;
         limit_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rate_ff      <= rate_in;
         offset_ff    <= offset_in;
         last_rpt_ff  <= last_rpt_in;
         last_good_ff <= last_good_in;
         exp_ff       <= exp_in;
         limit_ff     <= limit_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      ms_ff       <= ms_in;
      mlt_ff      <= mlt_in;
      dsel_ff     <= dsel_in;
      work_ff     <= work_in;
      stg_tick_ff <= stg_tick_in;
      stg_err_ff  <= stg_err_in;
      stg_rej_ff  <= stg_rej_in;
      rsp_ts_ff   <= rsp_ts_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_rej_ff  <= rsp_rej_in;
   end

endmodule

@@ sv/pscot_checker.sv @@
// Port-level checker for the clock offset tracker, bound to the top level.
`include "periodic_sync_clock_offset_tracker_macros.svh"

module pscot_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic [pscot_pkg::REQ_DATA_W-1:0]     req_tdata,
   input logic [pscot_pkg::REQ_USER_W-1:0]     req_tuser,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [pscot_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic [pscot_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input logic                                 csr_psel,
   input logic                                 csr_penable,
   input logic                                 csr_pwrite,
   input logic [pscot_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input logic [pscot_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   input logic [pscot_pkg::CSR_DATA_W-1:0]     csr_prdata,
   input logic                                 csr_pready
);
   import pscot_pkg::*;

   logic rate_write;
   logic rsp_stall;
   assign rate_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_TICK_RATE);
   assign rsp_stall  = rsp_tvalid && !rsp_tready;

   // Leaving reset: nothing pending, ready for a request word
   `PSCOT_ASSERT_NEXT(a_reset_clean, clock, 1'b0, reset, (!rsp_tvalid && req_tready), "response or busy after reset")

   // A stalled response word holds
   `PSCOT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)), "stalled response changed")

   // A rejected report always carries a nonzero error
   `PSCOT_ASSERT_SAME(a_reject_err, clock, reset, (rsp_tvalid && rsp_tuser[0]), (rsp_tdata[63:32] != 32'd0), "reject with zero error")

   // A rate write reads back masked to the register width
   `PSCOT_ASSERT_NEXT(a_rate_readback, clock, reset, rate_write, ((csr_paddr[2] != REG_TICK_RATE) || (csr_prdata == ($past(csr_pwdata) & 32'h000F_FFFF))), "tick rate readback mismatch")

   // Register port never waits
   `PSCOT_ASSERT_SAME(a_pready, clock, reset, csr_psel, csr_pready, "register port not ready")

endmodule

bind periodic_sync_clock_offset_tracker pscot_checker u_pscot_checker (.*);
